[design/particle_swarm_update_engine_macros.svh]
// Assertion macros for the particle swarm engine checker
`ifndef PARTICLE_SWARM_UPDATE_ENGINE_MACROS_SVH
`define PARTICLE_SWARM_UPDATE_ENGINE_MACROS_SVH

`define PSE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define PSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/pse_pkg.sv]
package pse_pkg;

    localparam int DEF_MAX_PARTICLES = 32;
    localparam int DEF_MAX_DIMS      = 16;
    localparam int CONSTRICT_Q16     = 47055;

    localparam logic [2:0] REG_DIMS      = 3'd0;
    localparam logic [2:0] REG_PARTICLES = 3'd1;
    localparam logic [2:0] REG_LIMIT     = 3'd2;
    localparam logic [2:0] REG_PGAIN     = 3'd3;
    localparam logic [2:0] REG_GGAIN     = 3'd4;

    typedef enum logic [2:0] {
        ACT_LOAD   = 3'd0,
        ACT_SETFIT = 3'd1,
        ACT_UPDFIT = 3'd2,
        ACT_PICK   = 3'd3,
        ACT_MOVE   = 3'd4,
        ACT_RDBEST = 3'd5,
        ACT_RDPOS  = 3'd6,
        ACT_NONE   = 3'd7
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD1,
        ST_RD2,
        ST_MUL,
        ST_SUM,
        ST_SCALE,
        ST_WRITE,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_PICK_RD,
        ST_PICK_CMP,
        ST_FIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [31:0] value;
        logic [31:0] best_fitness;
        logic        improved;
        logic        saturated;
    } result_t;

endpackage

[design/particle_swarm_update_engine.sv]
// Update fitness on improvement copies each dim of the position into the personal best;
// pick best walks the particles.
// Throughput: one item in flight; the next transfer is accepted the cycle after the
// result transfer.
// Reset: control and best index cleared, configuration set to defaults; memories undefined.
module particle_swarm_update_engine
    import pse_pkg::*;
#(
    parameter int MAX_PARTICLES = DEF_MAX_PARTICLES,
    parameter int MAX_DIMS      = DEF_MAX_DIMS
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // action[2:0], particle[7:3], dim[11:8], position_in[43:12],
    // velocity_in[75:44], fitness_in[107:76], rand_personal[123:108],
    // rand_global[139:124], zero fill to 144
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // value_out[31:0], best_particle[36:32], best_fitness[68:37],
    // improved[69], saturated[70], zero fill to 72
    output logic [71:0]  m_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [30:0]  cfg_wdata
);

    localparam int PW    = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int DEPTH = MAX_PARTICLES * MAX_DIMS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [31:0] pos_mem [DEPTH];
    logic [31:0] vel_mem [DEPTH];
    logic [31:0] pb_mem  [DEPTH];
    logic [31:0] fit_mem [MAX_PARTICLES];

    logic [4:0]  dims_reg;
    logic [5:0]  parts_reg;
    logic [30:0] limit_reg;
    logic [15:0] pgain_reg, ggain_reg;

    state_t      state_reg, state_next;
    action_t     act_reg;
    logic [4:0]  p_reg;
    logic [3:0]  d_reg;
    logic [31:0] pin_reg, vin_reg, fin_reg;
    logic [15:0] r1_reg, r2_reg;
    logic [4:0]  best_reg;
    logic        ok_reg, pok_reg, dok_reg;
    logic [8:0]  cnt_reg;
    logic [31:0] x_reg, v_reg, gb_reg, rd_pos, rd_pb, rd_vel, rd_fit;
    logic [31:0] bestfit_reg;
    logic [8:0]  bi_reg;
    logic        improved_reg;
    logic        out_valid_reg;
    result_t     res_reg;
    logic [4:0]  res_best_reg;

    logic [AW-1:0] addr;
    logic [AW-1:0] gaddr;
    logic [AW-1:0] caddr;
    logic [8:0]    de, pe;
    logic signed [31:0] new_v, new_x;
    logic          sat;
    logic          pick_take;

    assign de = (dims_reg == 0) ? 9'd1 : ((32'(dims_reg) > MAX_DIMS) ? 9'(MAX_DIMS) : 9'(dims_reg));
    assign pe = (parts_reg == 0) ? 9'd1 :
                ((32'(parts_reg) > MAX_PARTICLES) ? 9'(MAX_PARTICLES) : 9'(parts_reg));
    assign addr  = AW'(32'(p_reg) * MAX_DIMS + 32'(d_reg));
    assign gaddr = AW'(32'(best_reg) * MAX_DIMS + 32'(d_reg));
    assign caddr = AW'(32'(p_reg) * MAX_DIMS + 32'(cnt_reg));
    assign pick_take = (cnt_reg == 9'd0) || ($signed(rd_fit) > $signed(bestfit_reg));

    assign s_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, res_reg.saturated, res_reg.improved, res_reg.best_fitness,
                       res_best_reg, res_reg.value};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg  <= 5'd16;
            parts_reg <= 6'd32;
            limit_reg <= 31'd65536;
            pgain_reg <= 16'd8192;
            ggain_reg <= 16'd8192;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DIMS:      dims_reg  <= cfg_wdata[4:0];
                REG_PARTICLES: parts_reg <= cfg_wdata[5:0];
                REG_LIMIT:     limit_reg <= cfg_wdata;
                REG_PGAIN:     pgain_reg <= cfg_wdata[15:0];
                REG_GGAIN:     ggain_reg <= cfg_wdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_tvalid && s_tready) state_next = ST_RD1;
            ST_RD1:      state_next = ST_RD2;
            ST_RD2:
            begin
                unique case (act_reg)
                    ACT_MOVE:   state_next = ok_reg ? ST_MUL : ST_FIT;
                    ACT_UPDFIT: state_next = ST_FIT;
                    ACT_PICK:   state_next = ST_PICK_RD;
                    default:    state_next = ST_FIT;
                endcase
            end
            ST_MUL:      state_next = ST_SUM;
            ST_SUM:      state_next = ST_SCALE;
            ST_SCALE:    state_next = ST_WRITE;
            ST_WRITE:    state_next = ST_FIT;
            ST_COPY_RD:  state_next = ST_COPY_WR;
            ST_COPY_WR:  state_next = (cnt_reg + 9'd1 >= de) ? ST_FIT : ST_COPY_RD;
            ST_PICK_RD:  state_next = ST_PICK_CMP;
            ST_PICK_CMP: state_next = (cnt_reg + 9'd1 >= pe) ? ST_FIT : ST_PICK_RD;
            ST_FIT:
            begin
                if (act_reg == ACT_UPDFIT && improved_reg && cnt_reg == 9'd0 &&
                    state_reg == ST_FIT && !res_reg.improved)
                    state_next = ST_COPY_RD;
                else
                    state_next = ST_DONE;
            end
            ST_DONE:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            best_reg      <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (m_tvalid && m_tready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_DONE)
                out_valid_reg <= 1'b1;
            if (state_reg == ST_PICK_CMP && state_next == ST_FIT)
                best_reg <= pick_take ? 5'(cnt_reg) : 5'(bi_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        rd_pos <= pos_mem[(state_reg == ST_COPY_RD) ? caddr : addr];
        rd_vel <= vel_mem[addr];
        rd_pb  <= pb_mem[(state_reg == ST_RD1) ? gaddr : addr];
        rd_fit <= fit_mem[(state_reg == ST_PICK_RD) ? PW'(cnt_reg) :
                          ((state_reg == ST_FIT) ? PW'(best_reg) : PW'(p_reg))];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    act_reg  <= action_t'(s_tdata[2:0]);
                    p_reg    <= s_tdata[7:3];
                    d_reg    <= s_tdata[11:8];
                    pin_reg  <= s_tdata[43:12];
                    vin_reg  <= s_tdata[75:44];
                    fin_reg  <= s_tdata[107:76];
                    r1_reg   <= s_tdata[123:108];
                    r2_reg   <= s_tdata[139:124];
                    pok_reg  <= 32'(s_tdata[7:3]) < MAX_PARTICLES;
                    dok_reg  <= 32'(s_tdata[11:8]) < MAX_DIMS;
                    ok_reg   <= (32'(s_tdata[7:3]) < MAX_PARTICLES) &&
                                (32'(s_tdata[11:8]) < MAX_DIMS);
                    cnt_reg  <= 9'd0;
                    improved_reg <= 1'b0;
                    res_reg  <= '0;
                end
            end
            ST_RD1:
            begin
                gb_reg <= 32'(0);
            end
            ST_RD2:
            begin
                gb_reg  <= rd_pb;
                x_reg   <= rd_pos;
                v_reg   <= rd_vel;
                improved_reg <= pok_reg && ($signed(rd_fit) < $signed(fin_reg));
                bi_reg  <= 9'd0;
                bestfit_reg <= rd_fit;
                cnt_reg <= 9'd0;
                unique case (act_reg)
                    ACT_LOAD:
                    begin
                        if (ok_reg)
                        begin
                            pos_mem[addr] <= pin_reg;
                            vel_mem[addr] <= vin_reg;
                            pb_mem[addr]  <= pin_reg;
                            res_reg.value <= pin_reg;
                        end
                    end
                    ACT_SETFIT:
                    begin
                        if (pok_reg)
                            fit_mem[PW'(p_reg)] <= fin_reg;
                    end
                    ACT_RDBEST:
                    begin
                        if (dok_reg)
                            res_reg.value <= rd_pb;
                    end
                    ACT_RDPOS:
                    begin
                        if (ok_reg)
                            res_reg.value <= rd_pos;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_WRITE:
            begin
                vel_mem[addr] <= new_v;
                pos_mem[addr] <= new_x;
                res_reg.value <= new_x;
                res_reg.saturated <= sat;
            end
            ST_COPY_WR:
            begin
                pb_mem[caddr] <= rd_pos;
                cnt_reg <= cnt_reg + 9'd1;
            end
            ST_PICK_RD:
            begin
            end
            ST_PICK_CMP:
            begin
                if (pick_take)
                begin
                    bi_reg      <= cnt_reg;
                    bestfit_reg <= rd_fit;
                end
                cnt_reg <= cnt_reg + 9'd1;
            end
            ST_FIT:
            begin
                if (act_reg == ACT_UPDFIT && improved_reg && !res_reg.improved)
                begin
                    fit_mem[PW'(p_reg)] <= fin_reg;
                    res_reg.improved <= 1'b1;
                end
            end
            ST_DONE:
            begin
                res_reg.best_fitness <= rd_fit;
                res_best_reg <= best_reg;
            end
            default:
            begin
            end
        endcase
    end

    pse_move_unit u_move (
        .clk   (clk),
        .phase (4'(state_reg)),
        .x     (x_reg),
        .v     (v_reg),
        .pb    (rd_pb),
        .gb    (gb_reg),
        .r1    (r1_reg),
        .r2    (r2_reg),
        .pgain (pgain_reg),
        .ggain (ggain_reg),
        .limit (limit_reg),
        .new_v (new_v),
        .new_x (new_x),
        .sat   (sat)
    );

endmodule

[design/pse_move_unit.sv]
module pse_move_unit
    import pse_pkg::*;
(
    input  logic               clk,
    input  logic [3:0]         phase,
    input  logic signed [31:0] x,
    input  logic signed [31:0] v,
    input  logic signed [31:0] pb,
    input  logic signed [31:0] gb,
    input  logic [15:0]        r1,
    input  logic [15:0]        r2,
    input  logic [15:0]        pgain,
    input  logic [15:0]        ggain,
    input  logic [30:0]        limit,
    output logic signed [31:0] new_v,
    output logic signed [31:0] new_x,
    output logic               sat
);

    logic [19:0]        u1_reg, u2_reg;
    logic signed [52:0] t1_reg, t2_reg;
    logic signed [38:0] r_reg;
    logic signed [31:0] nv_reg;
    logic               sat_reg;
    logic [31:0]        prod1, prod2;
    logic signed [54:0] sum;
    logic signed [38:0] rs;
    logic signed [55:0] sc;
    logic signed [39:0] nv;
    logic signed [33:0] nx;
    logic signed [33:0] lim;

    assign prod1 = r1 * pgain;
    assign prod2 = r2 * ggain;
    assign sum = {{7{v[31]}}, v, 16'd0} + 55'(t1_reg) + 55'(t2_reg);
    assign rs  = 39'((sum + 55'sd32768) >>> 16);
    assign sc  = 56'(r_reg) * 56'sd47055;
    assign nv  = 40'((sc + 56'sd32768) >>> 16);
    assign lim = {3'd0, limit};
    assign nx  = 34'(x) + 34'(nv_reg);

    always_ff @(posedge clk)
    begin
        case (phase)
            4'(ST_RD2):
            begin
                u1_reg <= prod1[31:12];
                u2_reg <= prod2[31:12];
            end
            4'(ST_MUL):
            begin
                t1_reg <= $signed({1'b0, u1_reg}) * (53'(pb) - 53'(x));
                t2_reg <= $signed({1'b0, u2_reg}) * (53'(gb) - 53'(x));
            end
            4'(ST_SUM):
            begin
                r_reg <= rs;
            end
            4'(ST_SCALE):
            begin
                sat_reg <= 1'b0;
                if (nv > 40'sd2147483647)
                begin
                    nv_reg  <= 32'sh7fffffff;
                    sat_reg <= 1'b1;
                end
                else if (nv < -40'sd2147483648)
                begin
                    nv_reg  <= 32'sh80000000;
                    sat_reg <= 1'b1;
                end
                else
                begin
                    nv_reg <= nv[31:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign new_v = nv_reg;
    assign sat   = sat_reg;
    assign new_x = (nx > lim) ? lim[31:0] : ((nx < -lim) ? 32'(-lim) : nx[31:0]);

endmodule

[design/pse_checker.sv]
`include "particle_swarm_update_engine_macros.svh"
module pse_checker
    import pse_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [143:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [71:0]  m_tdata
);

    `PSE_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `PSE_ASSERT_IMPL(a_no_accept_while_out, clk, rst_n, m_tvalid, !s_tready)
    `PSE_ASSERT_IMPL(a_fill_zero, clk, rst_n, m_tvalid, m_tdata[71] == 1'b0)
    `PSE_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)

endmodule

bind particle_swarm_update_engine pse_checker u_pse_checker (.*);
